/* sv/hrae_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrae_pkg
// Shared types, constants and lookup tables for the hall rotor angle estimator.
// ----------------------------------------------------------------------------
package hrae_pkg;

    localparam int TimeBits   = 20;
    localparam int RingDepth  = 6;
    localparam int PosBits    = 3;
    localparam int TotalBits  = 23;
    localparam int NumBits    = 26;
    localparam int DenBits    = 29;
    localparam int CntBits    = 5;

    localparam logic [NumBits-1:0] StepNumerator = 26'd546133;
    localparam logic [NumBits-1:0] RpmNumerator  = 26'd60000000;
    localparam logic [15:0]        StageOneRpm   = 16'd50;
    localparam logic [CntBits-1:0] DivSteps      = 5'd26;

    // register indexes on the configuration port
    localparam logic [2:0] RegDirection = 3'd0;
    localparam logic [2:0] RegSlowest   = 3'd1;
    localparam logic [2:0] RegFastest   = 3'd2;
    localparam logic [2:0] RegStall     = 3'd3;
    localparam logic [2:0] RegPoles     = 3'd4;
    localparam logic [2:0] RegSettle    = 3'd5;
    localparam logic [2:0] RegShift     = 3'd6;

    // start-up stages
    localparam logic [1:0] StageHold  = 2'd0;
    localparam logic [1:0] StageSlow  = 2'd1;
    localparam logic [1:0] StageTrack = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_FILT1,
        S_FILT2,
        S_STAGE,
        S_DIV_STEP,
        S_RING,
        S_MUL,
        S_DIV_RPM,
        S_SETTLE,
        S_FINISH
    } state_t;

    function automatic logic [15:0] edge_rise(input logic [2:0] c);
        logic [15:0] v;
        unique case (c)
            3'd1: v = 16'd63351;
            3'd2: v = 16'd39222;
            3'd3: v = 16'd48285;
            3'd4: v = 16'd17933;
            3'd5: v = 16'd8078;
            3'd6: v = 16'd30343;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] edge_fall(input logic [2:0] c);
        logic [15:0] v;
        unique case (c)
            3'd1: v = 16'd1498;
            3'd2: v = 16'd44749;
            3'd3: v = 16'd56801;
            3'd4: v = 16'd23163;
            3'd5: v = 16'd12089;
            3'd6: v = 16'd34123;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] centre_angle(input logic [2:0] c);
        logic [15:0] v;
        unique case (c)
            3'd1: v = 16'd65201;
            3'd2: v = 16'd41595;
            3'd3: v = 16'd53298;
            3'd4: v = 16'd20881;
            3'd5: v = 16'd9899;
            3'd6: v = 16'd31712;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] width_rise(input logic [2:0] c);
        logic [15:0] v;
        unique case (c)
            3'd1: v = 16'd10263;
            3'd2: v = 16'd9063;
            3'd3: v = 16'd15067;
            3'd4: v = 16'd12410;
            3'd5: v = 16'd9854;
            3'd6: v = 16'd8879;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] width_fall(input logic [2:0] c);
        logic [15:0] v;
        unique case (c)
            3'd1: v = 16'd10231;
            3'd2: v = 16'd10627;
            3'd3: v = 16'd12053;
            3'd4: v = 16'd11070;
            3'd5: v = 16'd10591;
            3'd6: v = 16'd10964;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    // low-pass update, floor shift on both signs of the difference
    function automatic logic [TimeBits-1:0] smooth(input logic [TimeBits-1:0] filt,
                                                   input logic [TimeBits-1:0] sample,
                                                   input logic [2:0] sh);
        logic [TimeBits:0] d;
        logic [TimeBits:0] r;
        d = '0;
        r = '0;
        if (sample >= filt) begin
            d = {1'b0, sample - filt};
            r = {1'b0, filt} + (d >> sh);
        end else begin
            d = {1'b0, filt - sample} + ((TimeBits+1)'(1) << sh) - (TimeBits+1)'(1);
            r = {1'b0, filt} - (d >> sh);
        end
        return r[TimeBits-1:0];
    endfunction

endpackage

/* sv/hall_rotor_angle_estimator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hall_rotor_angle_estimator
// Electrical angle and speed estimate from hall codes, one word per tick.
// ----------------------------------------------------------------------------
// Usage: send one word per control tick on the s_ channel: tdata carries
// hall_code [2:0] and capture_time [22:3], tuser carries capture_valid.
// One result word comes back on the m_ channel: tdata holds the electrical
// angle [15:0] and speed_rpm [31:16]; tuser holds speed_update, first_stable,
// stall_res and hall_error from bit 0 up.
// Path of a word: a tick without a hall edge goes from S_EVAL to S_FINISH;
// an edge in the hold stage passes S_FILT1, S_FILT2, S_STAGE and S_SETTLE;
// the slow stage adds the angle-step divide, and the tracking stage adds
// S_RING, S_MUL and the rpm divide as well. One restoring divider (one
// quotient bit a cycle, 26 steps) is used for the angle step and the rpm.
// One word is in work at a time; s_tready is low until the result is in the
// output register, so no new word is taken while one is in work.
// A waiting result does not block the next word, but the next result is
// held until the receiver takes the first, and s_tready stays low meanwhile.
// Reset (aresetn low, synchronous) clears the estimator state and loads the
// register defaults; the first valid hall code loads the sector centre. The
// user writes registers over APB only while the block is idle; not enforced.
// ----------------------------------------------------------------------------
module hall_rotor_angle_estimator (
    input  logic        aclk,
    input  logic        aresetn,
    // hall_code [2:0], capture_time [22:3], zero [23]
    input  logic [23:0] s_tdata,
    // capture_valid [0]
    input  logic        s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // elec_angle [15:0], speed_rpm [31:16]
    output logic [31:0] m_tdata,
    // speed_update [0], first_stable [1], stall_res [2], hall_error [3]
    output logic [3:0]  m_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int TB = hrae_pkg::TimeBits;

    // configuration
    logic          dir_reg;
    logic [TB-1:0] slowest_reg, fastest_reg;
    logic [15:0]   stall_ticks_reg;
    logic [5:0]    poles_reg;
    logic [7:0]    settle_edges_reg;
    logic [2:0]    shift_reg;

    // tick inputs
    logic [2:0]    code_reg;
    logic          cap_valid_reg;
    logic [TB-1:0] cap_time_reg;

    // estimator state
    logic [2:0]    prev_code_reg;
    logic          started_reg;
    logic [15:0]   angle_reg;
    logic [TB-1:0] angle_step_reg;
    logic [15:0]   progress_reg;
    logic [15:0]   idle_ticks_reg;
    logic [1:0]    stage_reg;
    logic [TB-1:0] raw_reg, filt1_reg, filt2_reg, t_reg;
    logic [TB-1:0] ring_reg [hrae_pkg::RingDepth];
    logic [hrae_pkg::PosBits-1:0]   ring_pos_reg;
    logic [hrae_pkg::TotalBits-1:0] ring_total_reg;
    logic [7:0]    settle_count_reg;
    logic          stable_reg;
    logic [15:0]   speed_reg;
    logic          upd_reg, first_reg, stall_reg;

    // shared divider
    logic [hrae_pkg::NumBits-1:0] div_num_reg, div_quo_reg;
    logic [hrae_pkg::DenBits-1:0] div_den_reg, div_rem_reg;
    logic [hrae_pkg::CntBits-1:0] div_cnt_reg;

    logic [31:0]   m_tdata_reg;
    logic [3:0]    m_tuser_reg;
    logic          m_tvalid_reg;

    hrae_pkg::state_t state_reg, state_next;

    logic in_fire, out_free, cfg_wr, hall_ok;
    assign in_fire  = s_tvalid & s_tready;
    assign out_free = ~m_tvalid_reg | m_tready;
    assign cfg_wr   = psel & penable & pwrite & pready;
    assign hall_ok  = (code_reg != 3'd0) && (code_reg != 3'd7);
    assign s_tready = (state_reg == hrae_pkg::S_IDLE);
    assign pready   = 1'b1;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tvalid = m_tvalid_reg;

    // register read-back
    always_comb begin
        unique case (paddr[4:2])
            hrae_pkg::RegDirection: prdata = {31'd0, dir_reg};
            hrae_pkg::RegSlowest:   prdata = {12'd0, slowest_reg};
            hrae_pkg::RegFastest:   prdata = {12'd0, fastest_reg};
            hrae_pkg::RegStall:     prdata = {16'd0, stall_ticks_reg};
            hrae_pkg::RegPoles:     prdata = {26'd0, poles_reg};
            hrae_pkg::RegSettle:    prdata = {24'd0, settle_edges_reg};
            hrae_pkg::RegShift:     prdata = {29'd0, shift_reg};
            default:                prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_reg          <= 1'b0;
            slowest_reg      <= 20'd50000;
            fastest_reg      <= 20'd100;
            stall_ticks_reg  <= 16'd2000;
            poles_reg        <= 6'd4;
            settle_edges_reg <= 8'd6;
            shift_reg        <= 3'd2;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                hrae_pkg::RegDirection: dir_reg          <= pwdata[0];
                hrae_pkg::RegSlowest:   slowest_reg      <= pwdata[TB-1:0];
                hrae_pkg::RegFastest:   fastest_reg      <= pwdata[TB-1:0];
                hrae_pkg::RegStall:     stall_ticks_reg  <= pwdata[15:0];
                hrae_pkg::RegPoles:     poles_reg        <= pwdata[5:0];
                hrae_pkg::RegSettle:    settle_edges_reg <= pwdata[7:0];
                hrae_pkg::RegShift:     shift_reg        <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    // datapath helpers
    logic [TB-1:0]   t_clamp, sector_w;
    logic [TB:0]     prog_sum;
    logic [hrae_pkg::PosBits-1:0]   pos_use;
    logic [hrae_pkg::TotalBits-1:0] total_new;
    logic [hrae_pkg::DenBits:0]     div_trial;
    logic [5:0]      poles_use;
    logic            stage_div_done;

    always_comb begin
        t_clamp = filt2_reg;
        if (t_clamp <= fastest_reg) t_clamp = fastest_reg;
        if (t_clamp >= slowest_reg) t_clamp = slowest_reg;
        sector_w = TB'(dir_reg ? hrae_pkg::width_fall(prev_code_reg)
                               : hrae_pkg::width_rise(prev_code_reg));
        prog_sum  = {5'd0, progress_reg} + {1'b0, angle_step_reg};
        pos_use   = (ring_pos_reg >= hrae_pkg::PosBits'(hrae_pkg::RingDepth))
                    ? '0 : ring_pos_reg;
        total_new = ring_total_reg - hrae_pkg::TotalBits'(ring_reg[pos_use])
                    + hrae_pkg::TotalBits'(t_reg);
        poles_use = (poles_reg == 6'd0) ? 6'd1 : poles_reg;
        div_trial = {div_rem_reg, div_num_reg[hrae_pkg::NumBits-1]};
        stage_div_done = (div_cnt_reg == '0);
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= hrae_pkg::S_IDLE;
        else          state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            hrae_pkg::S_IDLE:  if (in_fire) state_next = hrae_pkg::S_EVAL;
            hrae_pkg::S_EVAL: begin
                if (started_reg && hall_ok && code_reg != prev_code_reg)
                    state_next = hrae_pkg::S_FILT1;
                else
                    state_next = hrae_pkg::S_FINISH;
            end
            hrae_pkg::S_FILT1: state_next = hrae_pkg::S_FILT2;
            hrae_pkg::S_FILT2: state_next = hrae_pkg::S_STAGE;
            hrae_pkg::S_STAGE: begin
                if (stage_reg == hrae_pkg::StageHold) state_next = hrae_pkg::S_SETTLE;
                else                                  state_next = hrae_pkg::S_DIV_STEP;
            end
            hrae_pkg::S_DIV_STEP: begin
                if (stage_div_done)
                    state_next = (stage_reg == hrae_pkg::StageTrack)
                                 ? hrae_pkg::S_RING : hrae_pkg::S_SETTLE;
            end
            hrae_pkg::S_RING: state_next = hrae_pkg::S_MUL;
            hrae_pkg::S_MUL: begin
                if (ring_total_reg == '0) state_next = hrae_pkg::S_SETTLE;
                else                      state_next = hrae_pkg::S_DIV_RPM;
            end
            hrae_pkg::S_DIV_RPM: if (stage_div_done) state_next = hrae_pkg::S_SETTLE;
            hrae_pkg::S_SETTLE: state_next = hrae_pkg::S_FINISH;
            hrae_pkg::S_FINISH: if (out_free) state_next = hrae_pkg::S_IDLE;
            default: state_next = hrae_pkg::S_IDLE;
        endcase
    end

    // estimator datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_code_reg    <= '0;
            started_reg      <= 1'b0;
            angle_reg        <= '0;
            angle_step_reg   <= '0;
            progress_reg     <= '0;
            idle_ticks_reg   <= '0;
            stage_reg        <= hrae_pkg::StageHold;
            raw_reg          <= '0;
            filt1_reg        <= '0;
            filt2_reg        <= '0;
            for (int i = 0; i < hrae_pkg::RingDepth; i++) ring_reg[i] <= '0;
            ring_pos_reg     <= '0;
            ring_total_reg   <= '0;
            settle_count_reg <= '0;
            stable_reg       <= 1'b0;
            speed_reg        <= '0;
            upd_reg          <= 1'b0;
            first_reg        <= 1'b0;
            stall_reg        <= 1'b0;
            div_cnt_reg      <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            // drop the result word once taken, unless a new one replaces it
            if (m_tvalid_reg && m_tready && state_reg != hrae_pkg::S_FINISH)
                m_tvalid_reg <= 1'b0;
            unique case (state_reg)
                hrae_pkg::S_IDLE: begin
                    // latch the tick word and drop last pulses
                    if (in_fire) begin
                        code_reg      <= s_tdata[2:0];
                        cap_time_reg  <= s_tdata[22:3];
                        cap_valid_reg <= s_tuser;
                        upd_reg       <= 1'b0;
                        first_reg     <= 1'b0;
                        stall_reg     <= 1'b0;
                    end
                end
                hrae_pkg::S_EVAL: begin
                    if (!started_reg) begin
                        // load the sector centre on the first valid code
                        if (hall_ok) begin
                            prev_code_reg <= code_reg;
                            angle_reg     <= hrae_pkg::centre_angle(code_reg);
                            started_reg   <= 1'b1;
                        end
                    end else if (hall_ok && code_reg != prev_code_reg) begin
                        // snap to the sector boundary, advance start-up stage
                        prev_code_reg  <= code_reg;
                        idle_ticks_reg <= '0;
                        progress_reg   <= '0;
                        angle_reg      <= dir_reg ? hrae_pkg::edge_fall(code_reg)
                                                  : hrae_pkg::edge_rise(code_reg);
                        if (cap_valid_reg) begin
                            if (stage_reg == hrae_pkg::StageHold) begin
                                stage_reg <= hrae_pkg::StageSlow;
                                raw_reg   <= '0;
                                filt1_reg <= '0;
                                filt2_reg <= '0;
                            end else begin
                                stage_reg <= hrae_pkg::StageTrack;
                                raw_reg   <= cap_time_reg;
                                if (filt1_reg == '0) begin
                                    filt1_reg <= cap_time_reg;
                                    filt2_reg <= cap_time_reg;
                                end
                            end
                        end
                    end else if (idle_ticks_reg < stall_ticks_reg) begin
                        // interpolate, limited by the sector width
                        idle_ticks_reg <= idle_ticks_reg + 16'd1;
                        if (prog_sum < {1'b0, sector_w}) begin
                            progress_reg <= prog_sum[15:0];
                            if (dir_reg) angle_reg <= angle_reg - angle_step_reg[15:0];
                            else         angle_reg <= angle_reg + angle_step_reg[15:0];
                        end
                    end else begin
                        // stall
                        idle_ticks_reg <= '0;
                        speed_reg      <= '0;
                        ring_total_reg <= '0;
                        stage_reg      <= hrae_pkg::StageHold;
                        upd_reg        <= 1'b1;
                        stall_reg      <= 1'b1;
                    end
                end
                hrae_pkg::S_FILT1: begin
                    if (raw_reg != '0)
                        filt1_reg <= hrae_pkg::smooth(filt1_reg, raw_reg, shift_reg);
                end
                hrae_pkg::S_FILT2: begin
                    if (raw_reg != '0)
                        filt2_reg <= hrae_pkg::smooth(filt2_reg, filt1_reg, shift_reg);
                end
                hrae_pkg::S_STAGE: begin
                    div_num_reg <= hrae_pkg::StepNumerator;
                    div_rem_reg <= '0;
                    unique case (stage_reg)
                        hrae_pkg::StageHold: begin
                            angle_step_reg <= '0;
                            speed_reg      <= '0;
                            ring_total_reg <= '0;
                            for (int i = 0; i < hrae_pkg::RingDepth; i++)
                                ring_reg[i] <= '0;
                            div_cnt_reg <= '0;
                        end
                        hrae_pkg::StageSlow: begin
                            div_cnt_reg <= hrae_pkg::DivSteps;
                            div_den_reg <= hrae_pkg::DenBits'((slowest_reg == '0)
                                                              ? TB'(1) : slowest_reg);
                        end
                        default: begin
                            div_cnt_reg <= hrae_pkg::DivSteps;
                            t_reg       <= t_clamp;
                            div_den_reg <= hrae_pkg::DenBits'((t_clamp == '0)
                                                              ? TB'(1) : t_clamp);
                        end
                    endcase
                end
                hrae_pkg::S_DIV_STEP: begin
                    if (stage_div_done) begin
                        angle_step_reg <= div_quo_reg[TB-1:0];
                        if (stage_reg == hrae_pkg::StageSlow) begin
                            for (int i = 0; i < hrae_pkg::RingDepth; i++)
                                ring_reg[i] <= raw_reg;
                            ring_total_reg <= hrae_pkg::TotalBits'(raw_reg)
                                              * hrae_pkg::TotalBits'(hrae_pkg::RingDepth);
                            speed_reg <= hrae_pkg::StageOneRpm;
                        end
                    end
                end
                hrae_pkg::S_RING: begin
                    // replace the oldest interval in the rpm ring
                    ring_reg[pos_use] <= t_reg;
                    ring_total_reg    <= total_new;
                    ring_pos_reg      <= (pos_use == hrae_pkg::PosBits'(hrae_pkg::RingDepth - 1))
                                         ? '0 : pos_use + hrae_pkg::PosBits'(1);
                end
                hrae_pkg::S_MUL: begin
                    div_num_reg <= hrae_pkg::RpmNumerator;
                    div_rem_reg <= '0;
                    div_den_reg <= hrae_pkg::DenBits'(ring_total_reg)
                                   * hrae_pkg::DenBits'(poles_use);
                    div_cnt_reg <= (ring_total_reg == '0) ? '0 : hrae_pkg::DivSteps;
                end
                hrae_pkg::S_DIV_RPM: begin
                    if (stage_div_done)
                        speed_reg <= (div_quo_reg > hrae_pkg::NumBits'(16'hFFFF))
                                     ? 16'hFFFF : div_quo_reg[15:0];
                end
                hrae_pkg::S_SETTLE: begin
                    if (settle_count_reg >= settle_edges_reg) begin
                        settle_count_reg <= settle_edges_reg;
                        if (!stable_reg) first_reg <= 1'b1;
                        stable_reg <= 1'b1;
                        upd_reg    <= 1'b1;
                    end else begin
                        settle_count_reg <= settle_count_reg + 8'd1;
                    end
                end
                hrae_pkg::S_FINISH: begin
                    if (out_free) begin
                        m_tdata_reg  <= {speed_reg, angle_reg};
                        m_tuser_reg  <= {~hall_ok, stall_reg, first_reg, upd_reg};
                        m_tvalid_reg <= 1'b1;
                    end
                end
                default: ;
            endcase

            // one restoring divide step a cycle
            if ((state_reg == hrae_pkg::S_DIV_STEP || state_reg == hrae_pkg::S_DIV_RPM)
                && !stage_div_done) begin
                if (div_trial >= {1'b0, div_den_reg}) begin
                    div_rem_reg <= hrae_pkg::DenBits'(div_trial - {1'b0, div_den_reg});
                    div_quo_reg <= {div_quo_reg[hrae_pkg::NumBits-2:0], 1'b1};
                end else begin
                    div_rem_reg <= div_trial[hrae_pkg::DenBits-1:0];
                    div_quo_reg <= {div_quo_reg[hrae_pkg::NumBits-2:0], 1'b0};
                end
                div_num_reg <= {div_num_reg[hrae_pkg::NumBits-2:0], 1'b0};
                div_cnt_reg <= div_cnt_reg - hrae_pkg::CntBits'(1);
            end
        end
    end

    // checks
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> !s_tready) else $error("input taken while busy");
    a_stable_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        !$fell(stable_reg)) else $error("stable flag dropped");
    a_stall_zero_speed: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[2]) |-> (m_tdata[31:16] == 16'd0))
        else $error("stall with non-zero speed");
    a_first_implies_upd: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> m_tuser[0]) else $error("first without update");
    a_div_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        div_cnt_reg <= hrae_pkg::DivSteps) else $error("divider count overrun");

endmodule
